[hw/rtl/distinct_filter_chunk_stager_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the distinct filter chunk stager
// Concurrent checks on the clock and asynchronous active-low reset.
// ----------------------------------------------------------------------------
`ifndef DISTINCT_FILTER_CHUNK_STAGER_CORE_ASSERT_SVH
`define DISTINCT_FILTER_CHUNK_STAGER_CORE_ASSERT_SVH

`ifndef SYNTH
// antecedent implies consequent in the same cycle
`define DFCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// antecedent implies consequent in the next cycle
`define DFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
// condition holds at every edge out of reset
`define DFCS_ASSERT_ALWAYS(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
		else $error("assertion failed: invariant");
`else
`define DFCS_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define DFCS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`define DFCS_ASSERT_ALWAYS(label, clk, rst_n, cond)
`endif

`endif

[hw/rtl/dfcs_pkg.sv]
// ----------------------------------------------------------------------------
// dfcs_pkg
// Shared widths, constants and controller/datapath interface types.
// ----------------------------------------------------------------------------
package dfcs_pkg;

	localparam int VAL_W  = 31;
	localparam int DIDX_W = 16;
	localparam int CNT_W  = 17;

	// multiplicative hash constant
	localparam logic [31:0]      HASH_MULT = 32'd2654435761;
	localparam logic [CNT_W-1:0] THR_RESET = 17'd1024;

	// controller to datapath
	typedef struct packed {
		logic clr;        // write an empty slot during the clearing pass
		logic take_in;    // latch input request and its hash
		logic end_mark;   // record end of stream for this source
		logic mod_step;   // one step of the slot reduction
		logic wr_new;     // store the value at the probe slot
		logic probe_next; // move to the next slot
		logic set_ovf;    // table full, set sticky flag
		logic emit_data;  // load output with a new value
		logic emit_done;  // load output with the done flush
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clr_last;  // clearing pass at its last slot
		logic ignore;    // request dropped outright
		logic is_end;    // end-of-stream request
		logic end_done;  // this end marker completes all sources
		logic data_skip; // zero value or destination full
		logic mod_done;  // slot index ready
		logic match;     // slot holds the value
		logic empty;     // slot is free
		logic full;      // whole table probed
		logic out_free;  // output register can take a result
	} sts_t;

endpackage

[hw/rtl/dfcs_ctrl.sv]
// ----------------------------------------------------------------------------
// dfcs_ctrl
// Sequencer: clearing pass, decode, slot reduction, probe loop and emit.
// ----------------------------------------------------------------------------
module dfcs_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  dfcs_pkg::sts_t  sts,
	output dfcs_pkg::cmd_t  cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_MOD,
		ST_READ,
		ST_CHECK,
		ST_EMIT_DATA,
		ST_EMIT_DONE
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == ST_IDLE);

	// commands per state
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_CLEAR: cmd.clr = 1'b1;
			ST_IDLE: cmd.take_in = in_valid;
			ST_DECODE: cmd.end_mark = !sts.ignore && sts.is_end;
			ST_MOD: cmd.mod_step = 1'b1;
			ST_READ: ;
			ST_CHECK: begin
				if (!sts.match) begin
					if (sts.empty) cmd.wr_new = 1'b1;
					else if (sts.full) cmd.set_ovf = 1'b1;
					else cmd.probe_next = 1'b1;
				end
			end
			ST_EMIT_DATA: cmd.emit_data = sts.out_free;
			ST_EMIT_DONE: cmd.emit_done = sts.out_free;
			default: ;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			case (state_q)
				ST_CLEAR: if (sts.clr_last) state_q <= ST_IDLE;
				ST_IDLE: if (in_valid) state_q <= ST_DECODE;
				ST_DECODE: begin
					if (sts.ignore) state_q <= ST_IDLE;
					else if (sts.is_end) state_q <= sts.end_done ? ST_EMIT_DONE : ST_IDLE;
					else if (sts.data_skip) state_q <= ST_IDLE;
					else state_q <= ST_MOD;
				end
				ST_MOD: if (sts.mod_done) state_q <= ST_READ;
				ST_READ: state_q <= ST_CHECK;
				ST_CHECK: begin
					if (sts.match) state_q <= ST_IDLE;
					else if (sts.empty || sts.full) state_q <= ST_EMIT_DATA;
					else state_q <= ST_READ;
				end
				ST_EMIT_DATA: if (sts.out_free) state_q <= ST_IDLE;
				ST_EMIT_DONE: if (sts.out_free) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

[hw/rtl/dfcs_datapath.sv]
// ----------------------------------------------------------------------------
// dfcs_datapath
// Seen-value table, hash and slot reduction, counters and output register.
// ----------------------------------------------------------------------------
`include "distinct_filter_chunk_stager_core_assert.svh"

module dfcs_datapath #(
	parameter int TABLE_ENTRIES = 65536,
	parameter int NUM_SOURCES   = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  dfcs_pkg::cmd_t                cmd,
	output dfcs_pkg::sts_t                sts,
	input  logic                          in_operation,
	input  logic                          in_source,
	input  logic [dfcs_pkg::VAL_W-1:0]    in_value,
	input  logic                          cfg_we,
	input  logic [dfcs_pkg::CNT_W-1:0]    cfg_data,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [dfcs_pkg::VAL_W-1:0]    out_unique_value,
	output logic [dfcs_pkg::DIDX_W-1:0]   out_dest_index,
	output logic                          out_chunk_last,
	output logic                          out_stream_done,
	output logic [dfcs_pkg::CNT_W-1:0]    out_total_count,
	output logic                          out_table_overflow
);

	localparam int IDX_W = $clog2(TABLE_ENTRIES);
	localparam bit POW2  = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
	localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);
	localparam logic [IDX_W:0]   TE_X      = (IDX_W + 1)'(TABLE_ENTRIES);
	localparam logic [31:0]      FOLD_C    = 32'((1 << IDX_W) - TABLE_ENTRIES);
	localparam logic [NUM_SOURCES-1:0] ALL_SRC = '1;
	localparam int VW = dfcs_pkg::VAL_W;
	localparam int CW = dfcs_pkg::CNT_W;

	// latched request
	logic                   op_q;
	logic                   src_q;
	logic [VW-1:0]          val_q;
	// hash and reduction
	logic [31:0]            prod;
	logic [31:0]            hash_q;
	logic [31:0]            fold_hi;
	logic [31:0]            fold_sum;
	logic                   fold_done;
	logic [IDX_W:0]         low_ext;
	logic [IDX_W:0]         low_red;
	// probe
	logic [IDX_W-1:0]       idx_q;
	logic [IDX_W-1:0]       idx_inc;
	logic [IDX_W-1:0]       pcnt_q;
	logic [VW-1:0]          rdata_q;
	logic [VW-1:0]          mem [TABLE_ENTRIES];
	// state counters
	logic [CW-1:0]          thr_q;
	logic [CW-1:0]          thr_eff;
	logic [CW-1:0]          ucnt_q;
	logic [CW-1:0]          pend_q;
	logic [CW-1:0]          pend_inc;
	logic [NUM_SOURCES-1:0] ended_q;
	logic [NUM_SOURCES-1:0] src_bit;
	logic                   ovf_q;
	logic                   chunk_close;

	assign prod = {1'b0, in_value} * dfcs_pkg::HASH_MULT;

	// fold the bits above the index width back in, 2^IDX_W equals FOLD_C
	// modulo the table size; each fold takes away a multiple of the size
	assign fold_hi   = hash_q >> IDX_W;
	assign fold_sum  = fold_hi * FOLD_C + 32'(hash_q[IDX_W-1:0]);
	assign fold_done = POW2 || (fold_hi == '0);

	// hash below 2^IDX_W: one compare and subtract finishes the reduction
	assign low_ext = {1'b0, hash_q[IDX_W-1:0]};
	assign low_red = (low_ext >= TE_X) ? (low_ext - TE_X) : low_ext;

	assign idx_inc = (idx_q == LAST_SLOT) ? '0 : idx_q + 1'b1;

	// source decode; a source index past the count yields a zero mask
	assign src_bit = NUM_SOURCES'(1) << src_q;

	assign thr_eff     = (thr_q == '0) ? CW'(1) : thr_q;
	assign pend_inc    = pend_q + 1'b1;
	assign chunk_close = (pend_inc >= thr_eff);

	// status
	always_comb begin
		sts.clr_last  = (idx_q == LAST_SLOT);
		sts.ignore    = (ended_q == ALL_SRC) || (src_bit == '0) || ((ended_q & src_bit) != '0);
		sts.is_end    = op_q;
		sts.end_done  = ((ended_q | src_bit) == ALL_SRC);
		sts.data_skip = (val_q == '0) || ucnt_q[CW-1];
		sts.mod_done  = fold_done;
		sts.match     = (rdata_q == val_q);
		sts.empty     = (rdata_q == '0);
		sts.full      = (pcnt_q == LAST_SLOT);
		sts.out_free  = !out_valid || out_ready;
	end

	// single-port table, read-first
	always_ff @(posedge clk) begin
		if (cmd.clr || cmd.wr_new) mem[idx_q] <= cmd.clr ? '0 : val_q;
		rdata_q <= mem[idx_q];
	end

	// request and reduction registers
	always_ff @(posedge clk) begin
		if (cmd.take_in) begin
			op_q   <= in_operation;
			src_q  <= in_source;
			val_q  <= in_value;
			hash_q <= prod;
		end else if (cmd.mod_step && !fold_done) begin
			hash_q <= fold_sum;
		end
	end

	// probe index and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pcnt_q <= '0;
		end else begin
			if (cmd.take_in) pcnt_q <= '0;
			if (cmd.mod_step && fold_done) idx_q <= low_red[IDX_W-1:0];
			if (cmd.clr || cmd.probe_next) idx_q <= idx_inc;
			if (cmd.probe_next) pcnt_q <= pcnt_q + 1'b1;
		end
	end

	// threshold register, counts, flags, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q     <= dfcs_pkg::THR_RESET;
			ucnt_q    <= '0;
			pend_q    <= '0;
			ended_q   <= '0;
			ovf_q     <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (cfg_we) thr_q <= cfg_data;
			if (cmd.end_mark) ended_q <= ended_q | src_bit;
			if (cmd.set_ovf) ovf_q <= 1'b1;
			if (cmd.emit_data) begin
				ucnt_q <= ucnt_q + 1'b1;
				pend_q <= chunk_close ? '0 : pend_inc;
			end
			if (cmd.emit_done) pend_q <= '0;
			if (cmd.emit_data || cmd.emit_done) out_valid <= 1'b1;
			else if (out_ready) out_valid <= 1'b0;
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (cmd.emit_data) begin
			out_unique_value   <= val_q;
			out_dest_index     <= ucnt_q[dfcs_pkg::DIDX_W-1:0];
			out_chunk_last     <= chunk_close;
			out_stream_done    <= 1'b0;
			out_total_count    <= ucnt_q + 1'b1;
			out_table_overflow <= ovf_q;
		end else if (cmd.emit_done) begin
			out_unique_value   <= '0;
			out_dest_index     <= '0;
			out_chunk_last     <= (pend_q != '0);
			out_stream_done    <= 1'b1;
			out_total_count    <= ucnt_q;
			out_table_overflow <= ovf_q;
		end
	end

	// checks
	`DFCS_ASSERT_IMPLY(a_emit_slot_free, clk, arst_n, cmd.emit_data || cmd.emit_done, sts.out_free)
	`DFCS_ASSERT_IMPLY(a_store_nonzero, clk, arst_n, cmd.wr_new, val_q != '0)
	`DFCS_ASSERT_ALWAYS(a_count_cap, clk, arst_n, !(ucnt_q[CW-1] && (ucnt_q[CW-2:0] != '0)))
	`DFCS_ASSERT_NEXT(a_done_shown, clk, arst_n, cmd.emit_done, out_valid && out_stream_done)

endmodule

[hw/rtl/distinct_filter_chunk_stager_core.sv]
// ----------------------------------------------------------------------------
// distinct_filter_chunk_stager_core
// Stream deduplication with a hashed seen-value table and chunked append output.
// ----------------------------------------------------------------------------
// Usage:
//  s_* takes requests: a data value or an end-of-stream marker from a source.
//  m_* returns at most one result per request: a first-seen value with its
//  append index and running count, or the done flush once all sources ended.
//  Duplicates, zero values and requests from ended or unknown sources give
//  no result. cfg_* writes the chunk threshold; write it only when idle.
// Steps per data request: accept, decode, slot reduction (folding the upper
//  hash bits repeatedly when TABLE_ENTRIES is not a power of two), then for
//  each probed slot a registered read of the single-port table followed by a
//  compare and possible insert, then a load of the output register when the
//  request gives a result.
// Reset: the table is swept to empty, one slot per cycle, with s_tready low;
//  cfg writes are taken during the sweep.
// Stall: a result waits in the output register while m_tready is low; the
//  next request is accepted meanwhile and holds only when it must emit.
// ----------------------------------------------------------------------------
module distinct_filter_chunk_stager_core #(
	parameter int TABLE_ENTRIES = 65536,
	parameter int NUM_SOURCES   = 2
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [30:0] value, [31] zero
	input  logic [1:0]  s_tuser,   // [0] operation, [1] source
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [30:0] unique_value, [46:31] dest_index,
	                               // [63:47] total_count
	output logic        m_tlast,   // chunk_last
	output logic [1:0]  m_tuser,   // [0] stream_done, [1] table_overflow
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [16:0] cfg_data   // chunk_threshold
);

	dfcs_pkg::cmd_t                cmd;
	dfcs_pkg::sts_t                sts;
	logic [dfcs_pkg::VAL_W-1:0]    o_value;
	logic [dfcs_pkg::DIDX_W-1:0]   o_index;
	logic [dfcs_pkg::CNT_W-1:0]    o_count;
	logic                          o_done;
	logic                          o_ovf;

	assign cfg_ready = 1'b1;

	dfcs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	dfcs_datapath #(
		.TABLE_ENTRIES (TABLE_ENTRIES),
		.NUM_SOURCES   (NUM_SOURCES)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.sts                (sts),
		.in_operation       (s_tuser[0]),
		.in_source          (s_tuser[1]),
		.in_value           (s_tdata[30:0]),
		.cfg_we             (cfg_valid && cfg_ready),
		.cfg_data           (cfg_data),
		.out_valid          (m_tvalid),
		.out_ready          (m_tready),
		.out_unique_value   (o_value),
		.out_dest_index     (o_index),
		.out_chunk_last     (m_tlast),
		.out_stream_done    (o_done),
		.out_total_count    (o_count),
		.out_table_overflow (o_ovf)
	);

	// result packing
	assign m_tdata = {o_count, o_index, o_value};
	assign m_tuser = {o_ovf, o_done};

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb: distinct filter chunk stager testbench
// Drives data values and end-of-stream markers from both sources and predicts
// every result with a software copy of the seen-value set: extreme values,
// probe chains that wrap around the table, threshold extremes, random traffic
// with random idling on both sides, a long probe chain on one slot, and the
// final done flush.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SLOTS        = 65536;
	localparam int SOURCES      = 2;
	localparam int DEST_LIMIT   = 65536;
	localparam int IDLE_LIMIT   = 400000;
	localparam int DRAIN_CYCLES = 100;

	localparam logic OP_DATA = 1'b0;
	localparam logic OP_END  = 1'b1;

	typedef enum {PROBE_STORED, PROBE_PRESENT, PROBE_FULL} probe_outcome_t;

	typedef struct {
		logic [dfcs_pkg::VAL_W-1:0]  value;
		logic [dfcs_pkg::DIDX_W-1:0] index;
		logic                        chunk_last;
		logic                        done;
		logic [dfcs_pkg::CNT_W-1:0]  total;
		logic                        overflow;
	} stage_result_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata   = '0;
	logic [1:0]  s_tuser   = '0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [63:0] m_tdata;
	logic        m_tlast;
	logic [1:0]  m_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [16:0] cfg_data  = '0;

	// predicted block state
	logic [dfcs_pkg::VAL_W-1:0] seen_slots [SLOTS];
	int unsigned                unique_total;
	int unsigned                chunk_fill;
	logic [SOURCES-1:0]         ended_mask;
	logic                       overflow_seen;
	logic [dfcs_pkg::CNT_W-1:0] threshold;

	stage_result_t              staged_results [$];
	logic [dfcs_pkg::VAL_W-1:0] sent_values [$];
	logic [31:0]                hash_inv;
	int                         errors       = 0;
	int                         idle_cycles  = 0;
	int                         tx_max_gap   = 10;
	int                         rx_max_stall = 10;

	always #1 clk = ~clk;

	distinct_filter_chunk_stager_core #(
		.TABLE_ENTRIES(SLOTS),
		.NUM_SOURCES(SOURCES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),     // [30:0] value, [31] zero
		.s_tuser(s_tuser),     // [0] operation, [1] source
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),     // [30:0] unique_value, [46:31] dest_index, [63:47] total_count
		.m_tlast(m_tlast),     // chunk_last
		.m_tuser(m_tuser),     // [0] stream_done, [1] table_overflow
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)    // chunk_threshold
	);

	function automatic int unsigned home_slot(input logic [dfcs_pkg::VAL_W-1:0] v);
		logic [31:0] h;
		h = {1'b0, v} * dfcs_pkg::HASH_MULT;
		return h % SLOTS;
	endfunction

	// value whose home slot is the given one; upper bits do not move the slot
	function automatic logic [dfcs_pkg::VAL_W-1:0] value_at_slot(input int unsigned slot,
			input logic [14:0] upper);
		logic [31:0] low;
		low = slot * hash_inv;
		return {upper, low[15:0]};
	endfunction

	// update the predicted state for one request, return 1 if it gives a result
	function automatic bit stage_request(input logic op, input logic src,
			input logic [dfcs_pkg::VAL_W-1:0] v, output stage_result_t r);
		int unsigned    idx;
		int unsigned    thr;
		probe_outcome_t probe;
		r = '{default: '0};
		if (&ended_mask)
			return 0;
		if (src >= SOURCES || ended_mask[src])
			return 0;
		if (op == OP_END) begin
			ended_mask[src] = 1'b1;
			if (!(&ended_mask))
				return 0;
			// done flush closes a chunk only if one is open
			r.chunk_last = (chunk_fill > 0);
			chunk_fill = 0;
			r.done = 1'b1;
			r.total = unique_total[dfcs_pkg::CNT_W-1:0];
			r.overflow = overflow_seen;
			return 1;
		end
		if (v == '0 || unique_total >= DEST_LIMIT)
			return 0;
		// linear probe with wrap
		idx = home_slot(v);
		probe = PROBE_FULL;
		for (int i = 0; i < SLOTS; i++) begin
			if (seen_slots[idx] == v) begin
				probe = PROBE_PRESENT;
				break;
			end
			if (seen_slots[idx] == '0) begin
				seen_slots[idx] = v;
				probe = PROBE_STORED;
				break;
			end
			idx = (idx + 1) % SLOTS;
		end
		if (probe == PROBE_PRESENT)
			return 0;
		if (probe == PROBE_FULL)
			overflow_seen = 1'b1;
		thr = (threshold == '0) ? 1 : threshold;
		r.value = v;
		r.index = unique_total[dfcs_pkg::DIDX_W-1:0];
		unique_total++;
		chunk_fill++;
		if (chunk_fill >= thr) begin
			r.chunk_last = 1'b1;
			chunk_fill = 0;
		end
		r.total = unique_total[dfcs_pkg::CNT_W-1:0];
		r.overflow = overflow_seen;
		return 1;
	endfunction

	// one request on the slave side, after a random gap
	task automatic send_request(input logic op, input logic src,
			input logic [dfcs_pkg::VAL_W-1:0] v);
		int            gap;
		stage_result_t r;
		gap = $urandom_range(0, tx_max_gap);
		@(negedge clk);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, v};
		s_tuser <= {src, op};
		do @(posedge clk); while (!s_tready);
		if (stage_request(op, src, v, r))
			staged_results.push_back(r);
		if (op == OP_DATA && v != '0)
			sent_values.push_back(v);
	endtask

	// data request from a random source: mostly fresh values, with repeats,
	// home-slot collisions, zeros and small values mixed in
	task automatic random_data_request();
		int                         pick;
		logic [dfcs_pkg::VAL_W-1:0] v;
		pick = $urandom_range(0, 99);
		if (pick < 55 || sent_values.size() == 0)
			v = dfcs_pkg::VAL_W'($urandom);
		else if (pick < 75)
			v = sent_values[$urandom_range(0, sent_values.size() - 1)];
		else if (pick < 90)
			v = sent_values[$urandom_range(0, sent_values.size() - 1)]
				+ (dfcs_pkg::VAL_W'($urandom_range(1, 7)) << 16);
		else if (pick < 95)
			v = '0;
		else
			v = dfcs_pkg::VAL_W'($urandom_range(1, 64));
		send_request(OP_DATA, 1'($urandom_range(0, 1)), v);
	endtask

	task automatic write_threshold(input logic [dfcs_pkg::CNT_W-1:0] thr);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= thr;
		do @(posedge clk); while (!cfg_ready);
		threshold = thr;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait for every staged result, then let any dropped request finish
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (staged_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic check_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	// extremes, duplicates, zero and probe chains across the table end
	task automatic test_directed_values();
		logic [dfcs_pkg::VAL_W-1:0] chain [3];
		write_threshold(17'd3);
		send_request(OP_DATA, 1'b0, 31'd1);
		send_request(OP_DATA, 1'b1, 31'h7FFFFFFF);
		send_request(OP_DATA, 1'b0, 31'd0);
		send_request(OP_DATA, 1'b1, 31'd1);
		send_request(OP_DATA, 1'b0, 31'h7FFFFFFF);
		send_request(OP_DATA, 1'b0, 31'h55555555);
		send_request(OP_DATA, 1'b1, 31'h2AAAAAAA);
		// three values homed on the last slot wrap into slots 0 and 1
		for (int k = 0; k < 3; k++) begin
			chain[k] = value_at_slot(SLOTS - 1, 15'(k + 1));
			send_request(OP_DATA, 1'(k), chain[k]);
		end
		send_request(OP_DATA, 1'b0, value_at_slot(0, 15'd5));
		send_request(OP_DATA, 1'b1, value_at_slot(1, 15'd6));
		// repeats: one found only after passing the wrap, one at its home slot
		send_request(OP_DATA, 1'b0, chain[2]);
		send_request(OP_DATA, 1'b1, chain[0]);
		drain_results();
	endtask

	// one value per chunk, with zero standing for one
	task automatic test_threshold_extremes();
		write_threshold(17'd1);
		repeat (3) random_data_request();
		drain_results();
		write_threshold(17'd0);
		repeat (3) random_data_request();
		drain_results();
	endtask

	// random traffic over several thresholds and idling patterns
	task automatic test_random_traffic();
		logic [dfcs_pkg::CNT_W-1:0] plan [7];
		plan = '{17'd2, 17'd7, 17'h10000, 17'h1FFFF, 17'd1024, 17'd5, 17'd1};
		for (int p = 0; p < 7; p++) begin
			write_threshold(plan[p]);
			tx_max_gap = (p % 3 == 0) ? 10 : 0;
			rx_max_stall = (p % 3 == 1) ? 0 : 10;
			repeat (75) random_data_request();
			drain_results();
		end
		tx_max_gap = 10;
		rx_max_stall = 10;
	endtask

	// source 1 ends; its later data and a second end marker are dropped
	task automatic test_ended_source();
		write_threshold(17'd4096);
		send_request(OP_END, 1'b1, dfcs_pkg::VAL_W'($urandom));
		send_request(OP_DATA, 1'b1, dfcs_pkg::VAL_W'($urandom));
		send_request(OP_END, 1'b1, '0);
	endtask

	// values homed on one slot build a long probe chain; repeats walk it
	task automatic test_collision_chain();
		int unsigned                slot;
		logic [dfcs_pkg::VAL_W-1:0] chain [8];
		slot = $urandom_range(0, SLOTS - 1);
		for (int k = 0; k < 8; k++) begin
			chain[k] = value_at_slot(slot, 15'(100 + k));
			send_request(OP_DATA, 1'b0, chain[k]);
		end
		send_request(OP_DATA, 1'b0, chain[7]);
		send_request(OP_DATA, 1'b0, chain[3]);
		drain_results();
	endtask

	// source 0 ends and its later data is dropped; the last end marker gives the done flush
	task automatic test_stream_done();
		send_request(OP_END, 1'b0, dfcs_pkg::VAL_W'($urandom));
		send_request(OP_DATA, 1'b0, dfcs_pkg::VAL_W'($urandom));
		send_request(OP_END, 1'b1, '0);
		drain_results();
	endtask

	// master side: random stall before each result
	initial begin
		int stall;
		forever begin
			stall = $urandom_range(0, rx_max_stall);
			if (stall > 0) begin
				@(negedge clk);
				m_tready <= 1'b0;
				repeat (stall - 1) @(negedge clk);
			end
			@(negedge clk);
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
		end
	end

	// result checker
	always @(posedge clk) begin
		stage_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (staged_results.size() == 0) begin
				$error("unexpected result: value %0d, done %0d", m_tdata[30:0], m_tuser[0]);
				errors++;
			end else begin
				want = staged_results.pop_front();
				check_field("unique_value", want.value, m_tdata[30:0]);
				check_field("dest_index", want.index, m_tdata[46:31]);
				check_field("total_count", want.total, m_tdata[63:47]);
				check_field("chunk_last", want.chunk_last, m_tlast);
				check_field("stream_done", want.done, m_tuser[0]);
				check_field("table_overflow", want.overflow, m_tuser[1]);
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		// modular inverse of the hash multiplier, Newton iteration
		hash_inv = dfcs_pkg::HASH_MULT;
		repeat (5) hash_inv = hash_inv * (32'd2 - dfcs_pkg::HASH_MULT * hash_inv);
		for (int i = 0; i < SLOTS; i++)
			seen_slots[i] = '0;
		unique_total = 0;
		chunk_fill = 0;
		ended_mask = '0;
		overflow_seen = 1'b0;
		threshold = dfcs_pkg::THR_RESET;

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed_values();
		test_threshold_extremes();
		test_random_traffic();
		test_ended_source();
		test_collision_chain();
		test_stream_done();

		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
